/* hw/rtl/ustdd_pkg.sv */
// ----------------------------------------------------------------------------
// ustdd_pkg: shared types and constants for the unix seconds to dos converter
// Widths, divider constants, the controller/datapath command bundle and the
// cumulative month tables.
// ----------------------------------------------------------------------------
package ustdd_pkg;

    // field widths
    localparam int SECONDS_WIDTH = 35;
    localparam int NSEC_W        = 30;
    localparam int ZONE_W        = 12;
    localparam int ZONE60_W      = 19;
    localparam int K_W           = 28;

    // adjusted seconds, wraps at 64 bits only for the widest input
    localparam int DIFF_W = (SECONDS_WIDTH < 64) ? SECONDS_WIDTH + 1 : 64;
    // seconds halved (two-second units) shifted into the 4-year cycle grid
    localparam int A_W    = DIFF_W - 1;

    // serial divider
    localparam int REM_W     = 26;
    localparam int CYC_PRE_W = 25;
    localparam int Q1_W      = A_W - CYC_PRE_W;
    localparam int CNT_W     = $clog2(Q1_W + 1);

    // quotient and remainder widths of the short divisions
    localparam int DAY_Q_W   = 11;
    localparam int HOUR_Q_W  = 6;
    localparam int MIN_Q_W   = 7;
    localparam int HDAY_W    = 16;
    localparam int HHOUR_W   = 11;

    // divisors, all in two-second units
    localparam logic [REM_W-1:0] DIV_CYCLE = REM_W'(63115200);
    localparam logic [REM_W-1:0] DIV_DAY   = REM_W'(43200);
    localparam logic [REM_W-1:0] DIV_HOUR  = REM_W'(1800);
    localparam logic [REM_W-1:0] DIV_MIN   = REM_W'(30);

    localparam logic [CNT_W-1:0] N_CYC  = CNT_W'(Q1_W);
    localparam logic [CNT_W-1:0] N_DAY  = CNT_W'(DAY_Q_W);
    localparam logic [CNT_W-1:0] N_HOUR = CNT_W'(HOUR_Q_W);
    localparam logic [CNT_W-1:0] N_MIN  = CNT_W'(MIN_Q_W);

    // 731 days from 1968-01-01 to 1970-01-01, in seconds
    localparam int OFFSET_SECS = 63158400;

    // nanoseconds / 10^7 by reciprocal multiply
    localparam logic [NSEC_W-1:0] NSEC_RECIP = NSEC_W'(900719926);
    localparam int NSEC_SHIFT = 53;
    localparam int PROD_W     = 2 * NSEC_W;
    localparam int NQ_W       = PROD_W - NSEC_SHIFT;

    // year window in 4-year cycles since 1968
    localparam int BASE_CYC    = 3;
    localparam int OVF_CYC     = 35;
    localparam int MONTH_COUNT = 11;

    // stream widths
    localparam int IN_TDATA_W  = ((SECONDS_WIDTH + NSEC_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [15:0] DATE_EPOCH = 16'h0021;

    typedef enum logic [1:0] {
        DS_CYC  = 2'd0,
        DS_DAY  = 2'd1,
        DS_HOUR = 2'd2,
        DS_MIN  = 2'd3
    } t_div_sel;

    typedef struct packed {
        logic     in_load;
        logic     prep;
        logic     div_load;
        t_div_sel div_sel;
        logic     cap_cyc;
        logic     cap_day;
        logic     cap_hour;
        logic     cap_min;
        logic     cap_year;
        logic     cap_month;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic div_idle;
    } t_stat;

    // days elapsed at the end of month idx
    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd31;
            4'd1:    v = leap ? 9'd60  : 9'd59;
            4'd2:    v = leap ? 9'd91  : 9'd90;
            4'd3:    v = leap ? 9'd121 : 9'd120;
            4'd4:    v = leap ? 9'd152 : 9'd151;
            4'd5:    v = leap ? 9'd182 : 9'd181;
            4'd6:    v = leap ? 9'd213 : 9'd212;
            4'd7:    v = leap ? 9'd244 : 9'd243;
            4'd8:    v = leap ? 9'd274 : 9'd273;
            4'd9:    v = leap ? 9'd305 : 9'd304;
            4'd10:   v = leap ? 9'd335 : 9'd334;
            4'd11:   v = leap ? 9'd366 : 9'd365;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/ustdd_divider.sv */
// ----------------------------------------------------------------------------
// ustdd_divider: shared restoring divider
// One quotient bit per cycle. The caller preloads the remainder with the top
// dividend bits and left-aligns the rest; the quotient fills in from bit 0.
// ----------------------------------------------------------------------------
module ustdd_divider import ustdd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [REM_W-1:0] i_rem_init,
    input  logic [A_W-1:0]   i_sh_init,
    input  logic [REM_W-1:0] i_divisor,
    input  logic [CNT_W-1:0] i_steps,
    output logic             o_idle,
    output logic [REM_W-1:0] o_rem,
    output logic [A_W-1:0]   o_quot
);

    logic [REM_W-1:0] r_rem, n_rem;
    logic [A_W-1:0]   r_sh, n_sh;
    logic [REM_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W:0]   w_trial;
    logic [REM_W:0]   w_diff;
    logic             w_ge;

    // one restoring step
    always_comb begin
        w_trial = {r_rem, r_sh[A_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
        n_sh    = {r_sh[A_W-2:0], w_ge};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem_init;
            r_sh  <= i_sh_init;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_idle = (r_cnt == '0);
    assign o_rem  = r_rem;
    assign o_quot = r_sh;

    a_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0))
        else $error("divider loaded while a division runs");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("divider step count skipped");

endmodule

/* hw/rtl/ustdd_datapath.sv */
// ----------------------------------------------------------------------------
// ustdd_datapath: operand registers, divider steering and field assembly
// Holds the zone offset, forms the adjusted two-second count, drives the
// shared divider through cycle, day, hour and minute splits, then resolves
// year and month and loads the output register.
// ----------------------------------------------------------------------------
module ustdd_datapath import ustdd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [ZONE_W-1:0]        i_cfg_wr_data,
    input  logic [SECONDS_WIDTH-1:0] i_secs,
    input  logic [NSEC_W-1:0]        i_nsec,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    output logic [15:0]              o_dos_date,
    output logic [15:0]              o_dos_time,
    output logic [7:0]               o_hundredths,
    output logic                     o_year_overflow
);

    logic [ZONE_W-1:0] r_zone;
    logic              r_neg;
    logic [A_W-1:0]    r_a;
    logic [NSEC_W-1:0] r_nsec;
    logic              r_odd;
    logic [NQ_W-1:0]   r_nq;
    logic [Q1_W-1:0]   r_cyc;
    logic [10:0]       r_rday;
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [4:0]        r_sec2;
    logic [8:0]        r_ry;
    logic              r_leap;
    logic [6:0]        r_yfield;
    logic              r_yovf;
    logic [3:0]        r_month;
    logic [4:0]        r_day;
    logic [15:0]       r_o_date;
    logic [15:0]       r_o_time;
    logic [7:0]        r_o_hund;
    logic              r_o_ovf;

    logic signed [SECONDS_WIDTH-1:0] w_secs_s;
    logic signed [ZONE_W-1:0]        w_zone_s;
    logic signed [ZONE60_W-1:0]      w_zone_x;
    logic signed [ZONE60_W-1:0]      w_zone60;
    logic signed [DIFF_W-1:0]        w_secs_x;
    logic signed [DIFF_W-1:0]        w_diff;
    logic signed [K_W-1:0]           w_k;
    logic signed [DIFF_W-1:0]        w_sum;
    logic [PROD_W-1:0]               w_prod;

    logic             w_div_idle;
    logic [REM_W-1:0] w_drem;
    logic [A_W-1:0]   w_dquot;
    logic [REM_W-1:0] w_rem_init;
    logic [A_W-1:0]   w_sh_init;
    logic [REM_W-1:0] w_divisor;
    logic [CNT_W-1:0] w_steps;

    logic [10:0] w_r2;
    logic [1:0]  w_k4;
    logic [8:0]  w_ry;
    logic [6:0]  w_ylow;
    logic        w_ypos;
    logic        w_yovf;
    logic [3:0]  w_mon;
    logic [8:0]  w_prev;
    logic [8:0]  w_day;

    // zone register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    // seconds minus zone, and the same plus the offset to the 1968 epoch
    always_comb begin
        w_secs_s = i_secs;
        w_zone_s = r_zone;
        w_zone_x = ZONE60_W'(w_zone_s);
        w_zone60 = (w_zone_x <<< 6) - (w_zone_x <<< 2);
        w_secs_x = DIFF_W'(w_secs_s);
        w_diff   = w_secs_x - DIFF_W'(w_zone60);
        w_k      = K_W'(w_zone60) - K_W'(OFFSET_SECS);
        w_sum    = w_secs_x - DIFF_W'(w_k);
    end

    // nanoseconds over ten million
    assign w_prod = PROD_W'(r_nsec) * PROD_W'(NSEC_RECIP);

    // divider operand steering
    always_comb begin
        case (i_cmd.div_sel)
            DS_CYC: begin
                w_rem_init = REM_W'(r_a[A_W-1:Q1_W]);
                w_sh_init  = {r_a[Q1_W-1:0], CYC_PRE_W'(0)};
                w_divisor  = DIV_CYCLE;
                w_steps    = N_CYC;
            end
            DS_DAY: begin
                w_rem_init = REM_W'(w_drem[REM_W-1:DAY_Q_W]);
                w_sh_init  = A_W'(w_drem[DAY_Q_W-1:0]) << (A_W - DAY_Q_W);
                w_divisor  = DIV_DAY;
                w_steps    = N_DAY;
            end
            DS_HOUR: begin
                w_rem_init = REM_W'(w_drem[HDAY_W-1:HOUR_Q_W]);
                w_sh_init  = A_W'(w_drem[HOUR_Q_W-1:0]) << (A_W - HOUR_Q_W);
                w_divisor  = DIV_HOUR;
                w_steps    = N_HOUR;
            end
            DS_MIN: begin
                w_rem_init = REM_W'(w_drem[HHOUR_W-1:MIN_Q_W]);
                w_sh_init  = A_W'(w_drem[MIN_Q_W-1:0]) << (A_W - MIN_Q_W);
                w_divisor  = DIV_MIN;
                w_steps    = N_MIN;
            end
            default: begin
                w_rem_init = '0;
                w_sh_init  = '0;
                w_divisor  = DIV_CYCLE;
                w_steps    = N_CYC;
            end
        endcase
    end

    ustdd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_rem_init (w_rem_init),
        .i_sh_init  (w_sh_init),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_idle     (w_div_idle),
        .o_rem      (w_drem),
        .o_quot     (w_dquot)
    );

    // year within the cycle and day within the year
    always_comb begin
        w_r2 = r_rday - 11'd366;
        if (r_rday < 11'd366) begin
            w_k4 = 2'd0;
            w_ry = r_rday[8:0];
        end else if (w_r2 >= 11'd730) begin
            w_k4 = 2'd3;
            w_ry = 9'(w_r2 - 11'd730);
        end else if (w_r2 >= 11'd365) begin
            w_k4 = 2'd2;
            w_ry = 9'(w_r2 - 11'd365);
        end else begin
            w_k4 = 2'd1;
            w_ry = w_r2[8:0];
        end
        w_ylow = {r_cyc[4:0], 2'b00} + {5'd0, w_k4} - 7'd12;
        w_ypos = (r_cyc > Q1_W'(BASE_CYC)) ||
                 ((r_cyc == Q1_W'(BASE_CYC)) && (w_k4 != 2'd0));
        w_yovf = (r_cyc >= Q1_W'(OVF_CYC));
    end

    // month search over the cumulative table
    always_comb begin
        w_mon = 4'd0;
        for (int m = 0; m < MONTH_COUNT; m++) begin
            if (r_ry >= cum_days(r_leap, 4'(m))) begin
                w_mon = 4'(m + 1);
            end
        end
        w_prev = (w_mon == 4'd0) ? 9'd0 : cum_days(r_leap, w_mon - 4'd1);
        w_day  = r_ry - w_prev + 9'd1;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_neg  <= w_diff[DIFF_W-1];
            r_a    <= w_sum[DIFF_W-1:1];
            r_nsec <= i_nsec;
            r_odd  <= i_secs[0];
        end
        if (i_cmd.prep) begin
            r_nq <= w_prod[PROD_W-1:NSEC_SHIFT];
        end
        if (i_cmd.cap_cyc) begin
            r_cyc <= w_dquot[Q1_W-1:0];
        end
        if (i_cmd.cap_day) begin
            r_rday <= w_dquot[DAY_Q_W-1:0];
        end
        if (i_cmd.cap_hour) begin
            r_hour <= w_dquot[4:0];
        end
        if (i_cmd.cap_min) begin
            r_min  <= w_dquot[5:0];
            r_sec2 <= w_drem[4:0];
        end
        if (i_cmd.cap_year) begin
            r_ry     <= w_ry;
            r_leap   <= (w_k4 == 2'd0);
            r_yfield <= w_ypos ? w_ylow : 7'd0;
            r_yovf   <= w_yovf;
        end
        if (i_cmd.cap_month) begin
            r_month <= w_mon + 4'd1;
            r_day   <= w_day[4:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_date <= r_neg ? DATE_EPOCH : {r_yfield, r_month, r_day};
            r_o_time <= r_neg ? 16'd0 : {r_hour, r_min, r_sec2};
            r_o_hund <= (r_odd ? 8'd100 : 8'd0) + 8'(r_nq);
            r_o_ovf  <= !r_neg && r_yovf;
        end
    end

    assign o_stat.neg      = r_neg;
    assign o_stat.div_idle = w_div_idle;
    assign o_dos_date      = r_o_date;
    assign o_dos_time      = r_o_time;
    assign o_hundredths    = r_o_hund;
    assign o_year_overflow = r_o_ovf;

endmodule

/* hw/rtl/ustdd_ctrl.sv */
// ----------------------------------------------------------------------------
// ustdd_ctrl: conversion sequencer (negative times go straight to the output)
// Accepts one request, walks the datapath through the four divisions and the
// calendar steps, and hands the result to the output register when it frees.
// ----------------------------------------------------------------------------
module ustdd_ctrl import ustdd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    output logic  o_m_valid,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_CYC   = 9'b000000100,
        S_DAY   = 9'b000001000,
        S_HOUR  = 9'b000010000,
        S_MIN   = 9'b000100000,
        S_YEAR  = 9'b001000000,
        S_MONTH = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.in_load = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                if (i_stat.neg) begin
                    n_state = S_DONE;
                end else begin
                    w_cmd.div_load = 1'b1;
                    w_cmd.div_sel  = DS_CYC;
                    n_state        = S_CYC;
                end
            end
            S_CYC: begin
                if (i_stat.div_idle) begin
                    w_cmd.cap_cyc  = 1'b1;
                    w_cmd.div_load = 1'b1;
                    w_cmd.div_sel  = DS_DAY;
                    n_state        = S_DAY;
                end
            end
            S_DAY: begin
                if (i_stat.div_idle) begin
                    w_cmd.cap_day  = 1'b1;
                    w_cmd.div_load = 1'b1;
                    w_cmd.div_sel  = DS_HOUR;
                    n_state        = S_HOUR;
                end
            end
            S_HOUR: begin
                if (i_stat.div_idle) begin
                    w_cmd.cap_hour = 1'b1;
                    w_cmd.div_load = 1'b1;
                    w_cmd.div_sel  = DS_MIN;
                    n_state        = S_MIN;
                end
            end
            S_MIN: begin
                if (i_stat.div_idle) begin
                    w_cmd.cap_min = 1'b1;
                    n_state       = S_YEAR;
                end
            end
            S_YEAR: begin
                w_cmd.cap_year = 1'b1;
                n_state        = S_MONTH;
            end
            S_MONTH: begin
                w_cmd.cap_month = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_cmd     = w_cmd;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_prep_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> i_stat.div_idle)
        else $error("divider still busy at start of a request");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_m_ready))
        else $error("output register overwritten before it was taken");

endmodule

/* hw/rtl/unix_seconds_to_dos_datetime.sv */
// ----------------------------------------------------------------------------
// unix_seconds_to_dos_datetime: signed unix seconds to packed dos date/time
// Converts local seconds since 1970 plus nanoseconds, less the zone offset,
// into the dos date word, dos time word, hundredths and a year overflow flag.
//
// Usage:
//   - slave stream: one request per tvalid/tready edge, tdata carries the
//     seconds and nanoseconds; tready is high only while no request is in work
//   - master stream: one result per request, held in an output register until
//     tready; a new request is accepted while that result still waits
//   - i_cfg_wr_en/i_cfg_wr_data load the signed zone offset in minutes; write
//     it only while the block is idle
//   - the shared serial divider runs the cycle, day, hour and minute splits,
//     one quotient bit per cycle
//   - times before 1970 skip the divisions
//   - reset clears the sequencer, the output valid flag and the zone offset
//   - a stalled master side holds the result and keeps the next one in the
//     sequencer until the output register frees
// ----------------------------------------------------------------------------
module unix_seconds_to_dos_datetime import ustdd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // zone offset register
    input  logic                   i_cfg_wr_en,
    input  logic [ZONE_W-1:0]      i_cfg_wr_data,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // local_seconds, nanoseconds, zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // dos_date, dos_time, hundredths
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // year_overflow
    output logic                   o_m_axis_tuser
);

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [15:0] w_date;
    logic [15:0] w_time;
    logic [7:0]  w_hund;
    logic        w_ovf;

    ustdd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    ustdd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_secs          (i_s_axis_tdata[SECONDS_WIDTH-1:0]),
        .i_nsec          (i_s_axis_tdata[SECONDS_WIDTH+NSEC_W-1:SECONDS_WIDTH]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_dos_date      (w_date),
        .o_dos_time      (w_time),
        .o_hundredths    (w_hund),
        .o_year_overflow (w_ovf)
    );

    // result packing, date in the low bits
    assign o_m_axis_tdata = {w_hund, w_time, w_date};
    assign o_m_axis_tuser = w_ovf;

endmodule
